[hdl/tun_pkg.sv]
// ----------------------------------------------------------------------------
// tun_pkg: shared types and widths for the triangle unit normal pipeline
// Holds the widths that the fixed-point normalization depends on.
// ----------------------------------------------------------------------------
`default_nettype none
package tun_pkg;
   localparam int TAG_BITS = 16;
   // the largest normalized magnitude lies in [2^29, 2^30)
   localparam int MAG_BITS = 30;
   localparam int SUMSQ_BITS = 62;
   localparam int ROOT_BITS = 31;

   typedef logic [TAG_BITS-1:0] tag_type;
endpackage
`default_nettype wire

[hdl/triangle_unit_normal.sv]
// ----------------------------------------------------------------------------
// triangle_unit_normal: unit face normal of one triangle per cycle
// pipeline: 7 front stages, 31 square root stages, NORMAL_BITS+1 divide stages
// and 1 output register
// throughput: one item per cycle, busy stays low; the pipeline never stalls
// reset clears all valid bits, payload registers are not reset
// ----------------------------------------------------------------------------
`default_nettype none
module triangle_unit_normal #(
   parameter int COORD_BITS = 24,
   parameter int NORMAL_BITS = 16
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         start,
   output logic                        busy,
   input  wire [15:0]                  req_tri_tag,
   input  wire signed [COORD_BITS-1:0] req_a_x,
   input  wire signed [COORD_BITS-1:0] req_a_y,
   input  wire signed [COORD_BITS-1:0] req_a_z,
   input  wire signed [COORD_BITS-1:0] req_b_x,
   input  wire signed [COORD_BITS-1:0] req_b_y,
   input  wire signed [COORD_BITS-1:0] req_b_z,
   input  wire signed [COORD_BITS-1:0] req_c_x,
   input  wire signed [COORD_BITS-1:0] req_c_y,
   input  wire signed [COORD_BITS-1:0] req_c_z,
   output logic                        rsp_valid,
   output logic [15:0]                 rsp_out_tag,
   output logic signed [NORMAL_BITS-1:0] rsp_normal_x,
   output logic signed [NORMAL_BITS-1:0] rsp_normal_y,
   output logic signed [NORMAL_BITS-1:0] rsp_normal_z,
   output logic                        rsp_degenerate
);
   localparam int EB = COORD_BITS + 1;
   localparam int PB = 2 * EB;
   localparam int NB = PB + 1;
   localparam int LB = $clog2(NB + 1);
   localparam int MB = tun_pkg::MAG_BITS;
   localparam int SB = tun_pkg::SUMSQ_BITS;
   localparam int RB = tun_pkg::ROOT_BITS;
   localparam int FRAC = NORMAL_BITS - 1;
   localparam int QB = NORMAL_BITS + 1;
   localparam int DNB = MB + FRAC + 1;
   // side band: tag, degenerate, 3 signs, 3 magnitudes
   localparam int SIDE1 = tun_pkg::TAG_BITS + 4 + 3 * MB;
   localparam int SIDE2 = tun_pkg::TAG_BITS + 4;

   assign busy = 1'b0;

   // stage 1: edges
   logic v1_ff;
   tun_pkg::tag_type t1_ff;
   logic signed [EB-1:0] ux_ff, uy_ff, uz_ff, vx_ff, vy_ff, vz_ff;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else v1_ff <= start;
      t1_ff <= req_tri_tag;
      ux_ff <= EB'(req_b_x) - EB'(req_a_x);
      uy_ff <= EB'(req_b_y) - EB'(req_a_y);
      uz_ff <= EB'(req_b_z) - EB'(req_a_z);
      vx_ff <= EB'(req_c_x) - EB'(req_a_x);
      vy_ff <= EB'(req_c_y) - EB'(req_a_y);
      vz_ff <= EB'(req_c_z) - EB'(req_a_z);
   end

   // stage 2: six products
   logic v2_ff;
   tun_pkg::tag_type t2_ff;
   logic signed [PB-1:0] p_ff [6];
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else v2_ff <= v1_ff;
      t2_ff <= t1_ff;
      p_ff[0] <= PB'(uy_ff * vz_ff);
      p_ff[1] <= PB'(uz_ff * vy_ff);
      p_ff[2] <= PB'(uz_ff * vx_ff);
      p_ff[3] <= PB'(ux_ff * vz_ff);
      p_ff[4] <= PB'(ux_ff * vy_ff);
      p_ff[5] <= PB'(uy_ff * vx_ff);
   end

   // stage 3: cross product, split into sign and magnitude
   logic v3_ff;
   tun_pkg::tag_type t3_ff;
   logic [2:0] neg3_ff;
   logic [NB-1:0] mag3_ff [3];
   logic signed [NB-1:0] n_in [3];
   always_comb begin
      n_in[0] = NB'(p_ff[0]) - NB'(p_ff[1]);
      n_in[1] = NB'(p_ff[2]) - NB'(p_ff[3]);
      n_in[2] = NB'(p_ff[4]) - NB'(p_ff[5]);
   end
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else v3_ff <= v2_ff;
      t3_ff <= t2_ff;
      for (int k = 0; k < 3; k++) begin
         neg3_ff[k] <= n_in[k][NB-1];
         mag3_ff[k] <= n_in[k][NB-1] ? NB'(-n_in[k]) : n_in[k];
      end
   end

   // stage 4: bit length of the or of magnitudes
   logic v4_ff;
   tun_pkg::tag_type t4_ff;
   logic [2:0] neg4_ff;
   logic [NB-1:0] mag4_ff [3];
   logic [LB-1:0] bl4_ff;
   logic [NB-1:0] or3;
   logic [LB-1:0] bl_in;
   always_comb begin
      or3 = mag3_ff[0] | mag3_ff[1] | mag3_ff[2];
      bl_in = '0;
      for (int i = 0; i < NB; i++) begin
         if (or3[i]) bl_in = LB'(i + 1);
      end
   end
   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else v4_ff <= v3_ff;
      t4_ff <= t3_ff;
      neg4_ff <= neg3_ff;
      mag4_ff <= mag3_ff;
      bl4_ff <= bl_in;
   end

   // stage 5: common shift so the largest lands in [2^29, 2^30)
   logic v5_ff;
   tun_pkg::tag_type t5_ff;
   logic [2:0] neg5_ff;
   logic deg5_ff;
   logic [MB-1:0] m5_ff [3];
   logic [NB+MB-1:0] wide [3];
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         wide[k] = {mag4_ff[k], {MB{1'b0}}} >> bl4_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else v5_ff <= v4_ff;
      t5_ff <= t4_ff;
      neg5_ff <= neg4_ff;
      deg5_ff <= (bl4_ff == '0);
      for (int k = 0; k < 3; k++) m5_ff[k] <= wide[k][MB-1:0];
   end

   // stage 6: squares
   logic v6_ff;
   tun_pkg::tag_type t6_ff;
   logic [2:0] neg6_ff;
   logic deg6_ff;
   logic [MB-1:0] m6_ff [3];
   logic [2*MB-1:0] sq6_ff [3];
   always_ff @(posedge clock) begin
      if (reset) v6_ff <= 1'b0;
      else v6_ff <= v5_ff;
      t6_ff <= t5_ff;
      neg6_ff <= neg5_ff;
      deg6_ff <= deg5_ff;
      m6_ff <= m5_ff;
      for (int k = 0; k < 3; k++) sq6_ff[k] <= m5_ff[k] * m5_ff[k];
   end

   // stage 7: sum of squares
   logic v7_ff;
   logic [SB-1:0] s7_ff;
   logic [SIDE1-1:0] side7_ff;
   always_ff @(posedge clock) begin
      if (reset) v7_ff <= 1'b0;
      else v7_ff <= v6_ff;
      s7_ff <= SB'(sq6_ff[0]) + SB'(sq6_ff[1]) + SB'(sq6_ff[2]);
      side7_ff <= {t6_ff, deg6_ff, neg6_ff, m6_ff[0], m6_ff[1], m6_ff[2]};
   end

   logic sq_v;
   logic [RB-1:0] sq_root;
   logic [SIDE1-1:0] sq_side;
   tun_isqrt #(.IN_BITS(SB), .SIDE_BITS(SIDE1)) u_isqrt (
      .clock(clock), .reset(reset),
      .in_valid(v7_ff), .in_value(s7_ff), .in_side(side7_ff),
      .out_valid(sq_v), .out_root(sq_root), .out_side(sq_side)
   );

   // three dividers share the length; avoid zero divisor on degenerate items
   logic [RB-1:0] den;
   logic [MB-1:0] mk [3];
   logic [SIDE2-1:0] side_d;
   assign den = (sq_root == '0) ? RB'(1) : sq_root;
   assign mk[0] = sq_side[3*MB-1 -: MB];
   assign mk[1] = sq_side[2*MB-1 -: MB];
   assign mk[2] = sq_side[MB-1:0];
   assign side_d = sq_side[SIDE1-1 -: SIDE2];

   logic [2:0] dv;
   logic [QB-1:0] q [3];
   logic [SIDE2-1:0] dside [3];
   for (genvar k = 0; k < 3; k++) begin : g_div
      logic [DNB-1:0] num;
      assign num = DNB'({mk[k], {FRAC{1'b0}}}) + DNB'(den[RB-1:1]);
      tun_divide #(.NUM_BITS(DNB), .DEN_BITS(RB), .Q_BITS(QB), .SIDE_BITS(SIDE2)) u_div (
         .clock(clock), .reset(reset),
         .in_valid(sq_v), .in_num(num), .in_den(den), .in_side(side_d),
         .out_valid(dv[k]), .out_quot(q[k]), .out_side(dside[k])
      );
   end

   // output stage: saturate, apply sign and zero degenerate items
   localparam logic [QB-1:0] FULL = QB'(1) << FRAC;
   logic [2:0] neg_o;
   logic deg_o;
   logic signed [NORMAL_BITS-1:0] nrm [3];
   assign neg_o = dside[0][2:0];
   assign deg_o = dside[0][3];
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         logic [QB-1:0] qs;
         qs = (q[k] > FULL) ? FULL : q[k];
         if (!neg_o[k] && qs > FULL - QB'(1)) qs = FULL - QB'(1);
         nrm[k] = neg_o[k] ? NORMAL_BITS'(-qs) : NORMAL_BITS'(qs);
         if (deg_o) nrm[k] = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid <= 1'b0;
      else rsp_valid <= dv[0];
      rsp_out_tag <= dside[0][SIDE2-1 -: tun_pkg::TAG_BITS];
      rsp_degenerate <= deg_o;
      rsp_normal_x <= nrm[0];
      rsp_normal_y <= nrm[1];
      rsp_normal_z <= nrm[2];
   end

   a_lanes_agree: assert property (@(posedge clock) disable iff (reset)
      dv[0] == dv[1] && dv[1] == dv[2])
      else $error("divider lanes out of step");
   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_normal_x == '0 && rsp_normal_y == '0
      && rsp_normal_z == '0)
      else $error("degenerate item with nonzero normal");
   a_no_busy: assert property (@(posedge clock) !busy)
      else $error("busy raised");
endmodule
`default_nettype wire

[hdl/tun_isqrt.sv]
// ----------------------------------------------------------------------------
// tun_isqrt: pipelined integer square root
// One result bit per stage, floor(sqrt(x)), an item may enter every cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module tun_isqrt #(
   parameter int IN_BITS = 62,
   parameter int SIDE_BITS = 8
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       in_valid,
   input  wire [IN_BITS-1:0]         in_value,
   input  wire [SIDE_BITS-1:0]       in_side,
   output logic                      out_valid,
   output logic [IN_BITS/2-1:0]      out_root,
   output logic [SIDE_BITS-1:0]      out_side
);
   localparam int STEPS = IN_BITS / 2;
   localparam int RB = IN_BITS / 2;

   logic [STEPS-1:0]             v_ff;
   logic [IN_BITS-1:0]           x_ff [STEPS-1];
   logic [RB-1:0]                rem_ff [STEPS-1];
   logic [RB-1:0]                r_ff [STEPS];
   logic [SIDE_BITS-1:0]         s_ff [STEPS];

   logic [IN_BITS-1:0]           x_cur [STEPS];
   logic [RB-1:0]                r_cur [STEPS];
   logic [RB-1:0]                rem_cur [STEPS];
   logic [RB+1:0]                cur [STEPS];
   logic [RB+1:0]                trial [STEPS];

   // restoring digit recurrence, two input bits consumed per stage
   always_comb begin
      x_cur[0] = in_value;
      r_cur[0] = '0;
      rem_cur[0] = '0;
      for (int i = 1; i < STEPS; i++) begin
         x_cur[i] = x_ff[i-1];
         r_cur[i] = r_ff[i-1];
         rem_cur[i] = rem_ff[i-1];
      end
      for (int i = 0; i < STEPS; i++) begin
         cur[i] = {rem_cur[i], x_cur[i][IN_BITS-1 -: 2]};
         trial[i] = cur[i] - {r_cur[i], 2'b01};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[STEPS-2:0], in_valid};
      end
      s_ff[0] <= in_side;
      for (int i = 1; i < STEPS; i++) s_ff[i] <= s_ff[i-1];
      for (int i = 0; i < STEPS; i++) begin
         r_ff[i] <= {r_cur[i][RB-2:0], !trial[i][RB+1]};
      end
      // the last stage only produces the root
      for (int i = 0; i < STEPS-1; i++) begin
         x_ff[i] <= {x_cur[i][IN_BITS-3:0], 2'b00};
         rem_ff[i] <= trial[i][RB+1] ? cur[i][RB-1:0] : trial[i][RB-1:0];
      end
   end

   assign out_valid = v_ff[STEPS-1];
   assign out_root = r_ff[STEPS-1];
   assign out_side = s_ff[STEPS-1];
endmodule
`default_nettype wire

[hdl/tun_divide.sv]
// ----------------------------------------------------------------------------
// tun_divide: pipelined unsigned divider
// Restoring division, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module tun_divide #(
   parameter int NUM_BITS = 46,
   parameter int DEN_BITS = 31,
   parameter int Q_BITS = 17,
   parameter int SIDE_BITS = 8
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   in_valid,
   input  wire [NUM_BITS-1:0]    in_num,
   input  wire [DEN_BITS-1:0]    in_den,
   input  wire [SIDE_BITS-1:0]   in_side,
   output logic                  out_valid,
   output logic [Q_BITS-1:0]     out_quot,
   output logic [SIDE_BITS-1:0]  out_side
);
   // quotient is known to fit in Q_BITS, so only the low Q_BITS steps run
   localparam int PRE = NUM_BITS - Q_BITS;

   logic [Q_BITS-1:0]       v_ff;
   logic [Q_BITS-1:0]       n_ff [Q_BITS-1];
   logic [DEN_BITS-1:0]     d_ff [Q_BITS-1];
   logic [DEN_BITS-1:0]     rem_ff [Q_BITS-1];
   logic [Q_BITS-1:0]       q_ff [Q_BITS];
   logic [SIDE_BITS-1:0]    s_ff [Q_BITS];

   logic [Q_BITS-1:0]       n_cur [Q_BITS];
   logic [DEN_BITS-1:0]     d_cur [Q_BITS];
   logic [DEN_BITS-1:0]     rem_cur [Q_BITS];
   logic [Q_BITS-1:0]       q_cur [Q_BITS];
   logic [DEN_BITS:0]       cur [Q_BITS];
   logic [DEN_BITS+1:0]     trial [Q_BITS];

   always_comb begin
      // the top bits of the numerator are below the divisor
      n_cur[0] = in_num[Q_BITS-1:0];
      d_cur[0] = in_den;
      rem_cur[0] = DEN_BITS'(in_num[NUM_BITS-1 -: PRE]);
      q_cur[0] = '0;
      for (int i = 1; i < Q_BITS; i++) begin
         n_cur[i] = n_ff[i-1];
         d_cur[i] = d_ff[i-1];
         rem_cur[i] = rem_ff[i-1];
         q_cur[i] = q_ff[i-1];
      end
      for (int i = 0; i < Q_BITS; i++) begin
         cur[i] = {rem_cur[i], n_cur[i][Q_BITS-1]};
         trial[i] = {1'b0, cur[i]} - {2'b00, d_cur[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[Q_BITS-2:0], in_valid};
      end
      s_ff[0] <= in_side;
      for (int i = 1; i < Q_BITS; i++) s_ff[i] <= s_ff[i-1];
      for (int i = 0; i < Q_BITS; i++) begin
         q_ff[i] <= {q_cur[i][Q_BITS-2:0], !trial[i][DEN_BITS+1]};
      end
      for (int i = 0; i < Q_BITS-1; i++) begin
         n_ff[i] <= {n_cur[i][Q_BITS-2:0], 1'b0};
         d_ff[i] <= d_cur[i];
         rem_ff[i] <= trial[i][DEN_BITS+1] ? cur[i][DEN_BITS-1:0] : trial[i][DEN_BITS-1:0];
      end
   end

   assign out_valid = v_ff[Q_BITS-1];
   assign out_quot = q_ff[Q_BITS-1];
   assign out_side = s_ff[Q_BITS-1];
endmodule
`default_nettype wire
